FILE: src/psps_pkg.sv
// Shared types, constants and helpers of the penalty-skip path sprayer.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package psps_pkg;

    // Fixed field widths of the channels.
    localparam int PATH_ID_W   = 16;
    localparam int FEEDBACK_W  = 2;
    localparam int ENTROPY_W   = 16;
    localparam int PEN_PATHS_W = 9;
    localparam int PEN_W       = 4;
    localparam int LOG2_W      = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int LFSR_W      = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_PATH_INDEX_BITS = 8;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Penalty weights and generator constants.
    localparam logic [PEN_W-1:0]  PEN_ECN      = 4'd1;
    localparam logic [PEN_W-1:0]  PEN_NACK     = 4'd4;
    localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_POLY    = 16'hB400;

    // Register values after reset.
    localparam logic [LOG2_W-1:0]     RST_PATH_COUNT_LOG2 = 4'd8;
    localparam logic [PEN_W-1:0]      RST_MAX_PENALTY     = 4'd15;
    localparam logic [ENTROPY_W-1:0]  RST_UPPER_BITS      = 16'd0;

    typedef enum logic {
        REQ_FEEDBACK = 1'b0,
        REQ_ENTROPY  = 1'b1
    } t_req_type;

    typedef enum logic [FEEDBACK_W-1:0] {
        FB_GOOD    = 2'd0,
        FB_ECN     = 2'd1,
        FB_NACK    = 2'd2,
        FB_TIMEOUT = 2'd3
    } t_feedback;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATH_COUNT_LOG2 = 8'd0,
        CFG_MAX_PENALTY     = 8'd1,
        CFG_UPPER_BITS      = 8'd2,
        CFG_LFSR_SEED       = 8'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FB_UPD,
        BK_RQ_WALK
    } t_back_state;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [PEN_W-1:0]     max_penalty;
        logic [ENTROPY_W-1:0] upper_bits;
        logic                 seed_load;
        logic [LFSR_W-1:0]    seed_value;
    } t_cfg;

    // One step of the right-shifting Galois generator.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] value);
        logic [LFSR_W-1:0] shifted;
        shifted = {1'b0, value[LFSR_W-1:1]};
        return value[0] ? (shifted ^ LFSR_POLY) : shifted;
    endfunction

endpackage

FILE: src/psps_if.sv
// Valid/ready channel interfaces of the penalty-skip path sprayer.
// Depends on psps_pkg for the field widths.
interface psps_req_if;
    import psps_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [PATH_ID_W-1:0]  path_id;
    logic [FEEDBACK_W-1:0] feedback;

    modport source (output valid, req_type, path_id, feedback, input ready);
    modport sink   (input valid, req_type, path_id, feedback, output ready);
endinterface

interface psps_res_if;
    import psps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ENTROPY_W-1:0]   entropy;
    logic [PEN_PATHS_W-1:0] penalized_paths;

    modport source (output valid, entropy, penalized_paths, input ready);
    modport sink   (input valid, entropy, penalized_paths, output ready);
endinterface

interface psps_cfg_if;
    import psps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/psps_front.sv
// Front end: accepts requests and turns each into a queue command.
// Depends on psps_pkg and psps_req_if.
module psps_front #(
    parameter int PATH_INDEX_BITS = psps_pkg::DEF_PATH_INDEX_BITS
) (
    psps_req_if.sink                    i_req,
    input  logic                        i_full,
    input  logic                        i_hold,
    input  logic [PATH_INDEX_BITS-1:0]  i_mask,
    input  logic [psps_pkg::PEN_W-1:0]  i_max_penalty,
    output logic                        o_push,
    output logic [PATH_INDEX_BITS+psps_pkg::PEN_W:0] o_cmd
);
    import psps_pkg::*;

    logic [PEN_W-1:0] w_pen;
    logic             w_is_req;

    // Feedback is reduced to the penalty it adds; the back end never sees the code.
    always_comb begin
        case (t_feedback'(i_req.feedback))
            FB_GOOD:    w_pen = '0;
            FB_ECN:     w_pen = PEN_ECN;
            FB_NACK:    w_pen = PEN_NACK;
            FB_TIMEOUT: w_pen = i_max_penalty;
            default:    w_pen = '0;
        endcase
    end

    assign w_is_req    = (i_req.req_type == REQ_ENTROPY);
    assign i_req.ready = !i_full && !i_hold;
    assign o_push      = i_req.valid && i_req.ready;
    assign o_cmd       = {w_is_req, i_req.path_id[PATH_INDEX_BITS-1:0] & i_mask, w_pen};

endmodule

FILE: src/psps_queue.sv
// Short first-word-fall-through queue between the front and back ends.
// Depends on psps_pkg for its default depth.
module psps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import psps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_fill == CNT_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

FILE: src/psps_back.sv
// Back end: penalty table, rotating index, mask generator and result register.
// Depends on psps_pkg and psps_res_if.
module psps_back #(
    parameter int PATH_INDEX_BITS = psps_pkg::DEF_PATH_INDEX_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psps_pkg::t_cfg              i_cfg,
    input  logic [PATH_INDEX_BITS-1:0]  i_mask,
    input  logic                        i_q_valid,
    input  logic [PATH_INDEX_BITS+psps_pkg::PEN_W:0] i_q_data,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    psps_res_if.source                  o_res
);
    import psps_pkg::*;

    localparam int PIB    = PATH_INDEX_BITS;
    localparam int DEPTH  = 1 << PIB;
    localparam int CNT_W  = PIB + 1;
    localparam int STEP_W = PIB + 1;
    localparam int CMD_W  = PIB + PEN_W + 1;

    t_back_state          r_state, n_state;
    logic [PIB-1:0]       r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [PIB-1:0]       r_rot, n_rot;
    logic [PIB-1:0]       r_xm, n_xm;
    logic [LFSR_W-1:0]    r_lfsr, n_lfsr;
    logic [PIB-1:0]       r_e, n_e;
    logic [PEN_W-1:0]     r_pen, n_pen;
    logic                 r_first, n_first;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic                 r_out_valid, n_out_valid;
    logic [ENTROPY_W-1:0] r_out_entropy, n_out_entropy;
    logic [PEN_PATHS_W-1:0] r_out_pp, n_out_pp;

    logic [PEN_W-1:0]     r_table [DEPTH];
    logic [PEN_W-1:0]     r_rd_data;
    logic                 r_fwd;
    logic [PEN_W-1:0]     r_fwd_data;

    logic                 w_we;
    logic [PIB-1:0]       w_wa;
    logic [PEN_W-1:0]     w_wd;
    logic [PIB-1:0]       w_ra;
    logic [PEN_W-1:0]     w_rd;

    logic                 w_cmd_req;
    logic [PIB-1:0]       w_cmd_idx;
    logic [PEN_W-1:0]     w_cmd_pen;
    logic                 w_out_free;
    logic [STEP_W-1:0]    w_npaths;
    logic [STEP_W-1:0]    w_steps_inc;
    logic [PIB-1:0]       w_rot_inc;
    logic                 w_wrap;
    logic [LFSR_W-1:0]    w_lfsr_draw;
    logic [PIB-1:0]       w_xm_adv;
    logic [LFSR_W-1:0]    w_lfsr_adv;
    logic [PIB-1:0]       w_e_adv;
    logic [PIB-1:0]       w_e_head;
    logic [PEN_W:0]       w_sum;
    logic [PEN_W-1:0]     w_fb_val;
    logic [ENTROPY_W-1:0] w_entropy;

    assign w_cmd_req  = i_q_data[CMD_W-1];
    assign w_cmd_idx  = i_q_data[CMD_W-2:PEN_W];
    assign w_cmd_pen  = i_q_data[PEN_W-1:0];
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_rd       = r_fwd ? r_fwd_data : r_rd_data;

    // One advance of the rotating index, with a fresh mask drawn on wrap.
    assign w_npaths    = STEP_W'(i_mask) + STEP_W'(1);
    assign w_steps_inc = r_steps + STEP_W'(1);
    assign w_rot_inc   = ((r_rot & i_mask) + PIB'(1)) & i_mask;
    assign w_wrap      = (w_rot_inc == '0);
    assign w_lfsr_draw = lfsr_step(r_lfsr);
    assign w_xm_adv    = w_wrap ? (w_lfsr_draw[PIB-1:0] & i_mask) : r_xm;
    assign w_lfsr_adv  = w_wrap ? w_lfsr_draw : r_lfsr;
    assign w_e_adv     = (w_rot_inc ^ w_xm_adv) & i_mask;
    assign w_e_head    = (r_rot ^ r_xm) & i_mask;

    assign w_sum     = {1'b0, w_rd} + {1'b0, r_pen};
    assign w_fb_val  = (w_sum > {1'b0, i_cfg.max_penalty}) ? i_cfg.max_penalty
                                                            : w_sum[PEN_W-1:0];
    assign w_entropy = (i_cfg.upper_bits & ~ENTROPY_W'(i_mask)) | ENTROPY_W'(r_e);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_count       = r_count;
        n_rot         = r_rot;
        n_xm          = r_xm;
        n_lfsr        = r_lfsr;
        n_e           = r_e;
        n_pen         = r_pen;
        n_first       = r_first;
        n_steps       = r_steps;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_entropy = r_out_entropy;
        n_out_pp      = r_out_pp;
        w_we          = 1'b0;
        w_wa          = r_e;
        w_wd          = '0;
        w_ra          = r_e;
        o_q_pop       = 1'b0;

        case (r_state)
            BK_CLEAR: begin
                w_we       = 1'b1;
                w_wa       = r_clr_addr;
                n_clr_addr = r_clr_addr + PIB'(1);
                if (r_clr_addr == '1) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_q_valid && !w_cmd_req) begin
                    o_q_pop = 1'b1;
                    n_e     = w_cmd_idx;
                    n_pen   = w_cmd_pen;
                    w_ra    = w_cmd_idx;
                    n_state = BK_FB_UPD;
                end else if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    n_e     = w_e_head;
                    w_ra    = w_e_head;
                    n_first = 1'b1;
                    n_steps = '0;
                    n_state = BK_RQ_WALK;
                end
            end
            BK_FB_UPD: begin
                w_we = 1'b1;
                w_wd = w_fb_val;
                if (w_rd == '0 && w_fb_val != '0) begin
                    n_count = r_count + CNT_W'(1);
                end else if (w_rd != '0 && w_fb_val == '0 && r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
                n_state = BK_IDLE;
            end
            BK_RQ_WALK: begin
                // Every visit advances the index exactly once, whether it ends the walk or not.
                n_rot  = w_rot_inc;
                n_xm   = w_xm_adv;
                n_lfsr = w_lfsr_adv;
                if (w_rd != '0 && r_first) begin
                    w_we = 1'b1;
                    w_wd = w_rd - PEN_W'(1);
                    if (w_rd == PEN_W'(1) && r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                n_first = 1'b0;
                n_steps = w_steps_inc;
                if (w_rd == '0 || w_steps_inc > w_npaths) begin
                    n_out_valid   = 1'b1;
                    n_out_entropy = w_entropy;
                    n_out_pp      = PEN_PATHS_W'(n_count);
                    n_state       = BK_IDLE;
                end else begin
                    n_e  = w_e_adv;
                    w_ra = w_e_adv;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (i_cfg.seed_load) begin
            n_lfsr = i_cfg.seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_rot       <= '0;
            r_xm        <= '0;
            r_lfsr      <= SEED_DEFAULT;
            r_first     <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_rot       <= n_rot;
            r_xm        <= n_xm;
            r_lfsr      <= n_lfsr;
            r_first     <= n_first;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
            r_fwd       <= w_we && (w_wa == w_ra);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e           <= n_e;
        r_pen         <= n_pen;
        r_out_entropy <= n_out_entropy;
        r_out_pp      <= n_out_pp;
        r_fwd_data    <= w_wd;
    end

    // Penalty table: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_wa] <= w_wd;
        end
        r_rd_data <= r_table[w_ra];
    end

    assign o_clearing            = (r_state == BK_CLEAR);
    assign o_res.valid           = r_out_valid;
    assign o_res.entropy         = r_out_entropy;
    assign o_res.penalized_paths = r_out_pp;

endmodule

FILE: src/penalty_skip_path_sprayer_core.sv
// Top level of the penalty-skip path sprayer: configuration registers and the
// front end, command queue and back end. Depends on psps_pkg, the psps interfaces and modules.
//
// The block sprays requests over a power-of-two set of paths and steers them away
// from paths that have reported trouble. A feedback request (req_type 0) adds a
// penalty to one path: nothing for good, one for an ECN mark, four for a NACK and
// max_penalty for a timeout, saturating at max_penalty; it produces no result. An
// entropy request (req_type 1) walks a rotating index, permuted by an xor mask that
// is redrawn from a 16-bit Galois generator each time the index wraps, and skips
// paths with a nonzero penalty; the first penalised path it meets loses one point.
// The walk gives up after more than path-count steps and then returns the path
// where it stopped. Each entropy request yields exactly one result: the chosen path
// index under upper_bits, and the number of penalised paths in the whole table.
// After reset the penalty table is cleared by a sweep, one entry a cycle, during
// which no request is accepted; configuration writes are taken throughout.
// Requests enter a queue of QUEUE_DEPTH entries and are accepted whenever it has
// room, also while a result waits to be taken. The back end reads the penalty
// table once a cycle through a read port beside its write port, and finishes each
// request before it takes the next: a feedback request is read in the idle state
// and written in the update state, and an entropy request walks the paths one
// after another. An entropy request is started only when the result register is
// free or being emptied. Configuration is meant to be written while the block is idle.
module penalty_skip_path_sprayer_core #(
    parameter int PATH_INDEX_BITS = psps_pkg::DEF_PATH_INDEX_BITS,
    parameter int QUEUE_DEPTH     = psps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psps_req_if.sink   i_req,
    psps_res_if.source o_res,
    psps_cfg_if.sink   i_cfg
);
    import psps_pkg::*;

    localparam int CMD_W = PATH_INDEX_BITS + PEN_W + 1;

    logic [LOG2_W-1:0]          r_path_count_log2;
    logic [PEN_W-1:0]           r_max_penalty;
    logic [ENTROPY_W-1:0]       r_upper_bits;

    logic                       w_cfg_wr;
    logic                       w_seed_load;
    logic [LFSR_W-1:0]          w_seed_value;
    logic [LOG2_W-1:0]          w_active_log2;
    logic [PATH_INDEX_BITS-1:0] w_mask;
    t_cfg                       w_cfg;

    logic                       w_push;
    logic [CMD_W-1:0]           w_push_cmd;
    logic                       w_q_full;
    logic                       w_q_valid;
    logic [CMD_W-1:0]           w_q_data;
    logic                       w_q_pop;
    logic                       w_clearing;

    // The register port never stalls.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_count_log2 <= RST_PATH_COUNT_LOG2;
            r_max_penalty     <= RST_MAX_PENALTY;
            r_upper_bits      <= RST_UPPER_BITS;
        end else if (w_cfg_wr) begin
            case (i_cfg.index)
                CFG_PATH_COUNT_LOG2: r_path_count_log2 <= i_cfg.data[LOG2_W-1:0];
                CFG_MAX_PENALTY:     r_max_penalty     <= i_cfg.data[PEN_W-1:0];
                CFG_UPPER_BITS:      r_upper_bits      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Writing the seed reloads the generator at once; a zero seed would lock it,
    // so the default seed is loaded instead.
    assign w_seed_load  = w_cfg_wr && (i_cfg.index == CFG_LFSR_SEED);
    assign w_seed_value = (i_cfg.data != '0) ? i_cfg.data : SEED_DEFAULT;

    // A path count above the table size acts as the full table.
    assign w_active_log2 = (int'(r_path_count_log2) > PATH_INDEX_BITS)
                           ? LOG2_W'(PATH_INDEX_BITS) : r_path_count_log2;
    assign w_mask        = ~({PATH_INDEX_BITS{1'b1}} << w_active_log2);

    assign w_cfg = '{
        max_penalty: r_max_penalty,
        upper_bits:  r_upper_bits,
        seed_load:   w_seed_load,
        seed_value:  w_seed_value
    };

    psps_front #(
        .PATH_INDEX_BITS(PATH_INDEX_BITS)
    ) u_front (
        .i_req        (i_req),
        .i_full       (w_q_full),
        .i_hold       (w_clearing),
        .i_mask       (w_mask),
        .i_max_penalty(r_max_penalty),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    psps_queue #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_cmd),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_valid(w_q_valid),
        .o_data (w_q_data)
    );

    psps_back #(
        .PATH_INDEX_BITS(PATH_INDEX_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_mask    (w_mask),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_clearing(w_clearing),
        .o_res     (o_res)
    );

    // No request may enter while the penalty table is being cleared.
    a_no_accept_while_clearing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !(i_req.valid && i_req.ready)
    ) else $error("request accepted during the table clearing sweep");

    // The back end only takes a command that the queue holds.
    a_pop_only_when_valid : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid
    ) else $error("command queue popped while empty");

    // The penalised count can never exceed the table size.
    a_count_in_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (32'(o_res.penalized_paths) <= (32'd1 << PATH_INDEX_BITS))
    ) else $error("penalised path count exceeds the table size");

endmodule
